FILE: design/sebgb_pkg.sv
// ----------------------------------------------------------------------------
// sebgb_pkg: shared types and helpers for the sphere step block
// Request and response payloads, per-axis pipeline records, register codes,
// fixed point constants and Q16.16 rounding and saturation helpers.
// ----------------------------------------------------------------------------
package sebgb_pkg;

   localparam int DIV_STEPS  = 32;
   localparam int AXIS_LAT   = DIV_STEPS + 7;
   localparam int GROUND_LAT = 2;
   localparam int TOTAL_LAT  = 1 + AXIS_LAT + GROUND_LAT;

   localparam logic [16:0] ONE_Q         = 17'd65536;
   localparam logic [16:0] RESTITUTION_Q = 17'd45875;
   localparam logic [31:0] VY_REST_Q     = 32'd6554;
   localparam logic [31:0] VXZ_REST_Q    = 32'd656;

   localparam logic signed [31:0] GRAVITY_X_RST = 32'sd0;
   localparam logic signed [31:0] GRAVITY_Y_RST = -32'sd642908;
   localparam logic signed [31:0] GRAVITY_Z_RST = 32'sd0;
   localparam logic [30:0]        DRAG_RST      = 31'd6554;
   localparam logic [16:0]        FRICTION_RST  = 17'd32768;
   localparam logic signed [31:0] GROUND_RST    = 32'sd0;
   localparam logic [16:0]        TIME_STEP_RST = 17'd655;

   typedef enum logic [2:0] {
      CSR_GRAVITY_X = 3'd0,
      CSR_GRAVITY_Y = 3'd1,
      CSR_GRAVITY_Z = 3'd2,
      CSR_DRAG      = 3'd3,
      CSR_FRICTION  = 3'd4,
      CSR_GROUND    = 3'd5,
      CSR_TIME_STEP = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [30:0]        body_mass;
      logic [30:0]        body_radius;
      logic               is_fixed;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               hit_ground;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic [30:0]        mass;
      logic               ovf;
      logic               skip;
   } axis_side_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] pos_orig;
      logic signed [31:0] vel_orig;
   } axis_res_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         sat34 = 32'sh7FFFFFFF;
      end else if (v < -34'sd2147483648) begin
         sat34 = 32'sh80000000;
      end else begin
         sat34 = v[31:0];
      end
   endfunction

   function automatic logic signed [31:0] round_sat(input logic [49:0] prod, input logic neg);
      logic [49:0] r;
      logic        big;
      r   = (prod + 50'd32768) >> 16;
      big = |r[49:31];
      if (neg) begin
         round_sat = big ? 32'sh80000000 : -$signed({1'b0, r[30:0]});
      end else begin
         round_sat = big ? 32'sh7FFFFFFF : $signed({1'b0, r[30:0]});
      end
   endfunction

endpackage

FILE: design/sphere_euler_step_with_ground_bounce.sv
// ----------------------------------------------------------------------------
// sphere_euler_step_with_ground_bounce: one Euler step of a sphere
// Pipeline: an accepted request passes the input register, the axis
// pipelines with their 32-stage drag divider and the ground stages before
// rsp_valid rises. Throughput: one request per cycle, busy is low except in
// reset and the cycle after it. The receiver cannot stall. Reset:
// synchronous, clears the valid line and loads register defaults.
// ----------------------------------------------------------------------------
module sphere_euler_step_with_ground_bounce (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sebgb_pkg::req_type req_data,
   output logic               rsp_valid,
   output sebgb_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AL = sebgb_pkg::AXIS_LAT;
   localparam int TL = sebgb_pkg::TOTAL_LAT;

   logic signed [31:0] gravity_ff [3];
   logic [30:0]        drag_ff;
   logic [16:0]        friction_ff;
   logic signed [31:0] ground_ff;
   logic [16:0]        dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff[0] <= sebgb_pkg::GRAVITY_X_RST;
         gravity_ff[1] <= sebgb_pkg::GRAVITY_Y_RST;
         gravity_ff[2] <= sebgb_pkg::GRAVITY_Z_RST;
         drag_ff       <= sebgb_pkg::DRAG_RST;
         friction_ff   <= sebgb_pkg::FRICTION_RST;
         ground_ff     <= sebgb_pkg::GROUND_RST;
         dt_ff         <= sebgb_pkg::TIME_STEP_RST;
      end else if (csr_we) begin
         unique case (sebgb_pkg::csr_index_type'(csr_index))
            sebgb_pkg::CSR_GRAVITY_X: gravity_ff[0] <= csr_wdata;
            sebgb_pkg::CSR_GRAVITY_Y: gravity_ff[1] <= csr_wdata;
            sebgb_pkg::CSR_GRAVITY_Z: gravity_ff[2] <= csr_wdata;
            sebgb_pkg::CSR_DRAG:      drag_ff       <= csr_wdata[30:0];
            sebgb_pkg::CSR_FRICTION:  friction_ff   <= csr_wdata[16:0];
            sebgb_pkg::CSR_GROUND:    ground_ff     <= csr_wdata;
            sebgb_pkg::CSR_TIME_STEP: dt_ff         <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   logic          busy_ff;
   logic          accept;
   logic [TL-1:0] vld_ff;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff  <= {vld_ff[TL-2:0], accept};
      end
   end

   sebgb_pkg::req_type req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // radius and static flag follow the axis pipelines
   logic [30:0] rad_dly_ff [AL];
   logic [AL-1:0] fix_dly_ff;

   always_ff @(posedge clock) begin
      rad_dly_ff[0] <= req_ff.body_radius;
      for (int i = 1; i < AL; i++) begin
         rad_dly_ff[i] <= rad_dly_ff[i-1];
      end
      fix_dly_ff <= {fix_dly_ff[AL-2:0], req_ff.is_fixed};
   end

   sebgb_pkg::axis_res_type [2:0] ax_res;

   sebgb_axis u_axis_x (
      .clock     (clock),
      .gravity_i (gravity_ff[0]),
      .drag_i    (drag_ff),
      .dt_i      (dt_ff),
      .pos_i     (req_ff.pos_x),
      .vel_i     (req_ff.vel_x),
      .mass_i    (req_ff.body_mass),
      .res_o     (ax_res[0])
   );

   sebgb_axis u_axis_y (
      .clock     (clock),
      .gravity_i (gravity_ff[1]),
      .drag_i    (drag_ff),
      .dt_i      (dt_ff),
      .pos_i     (req_ff.pos_y),
      .vel_i     (req_ff.vel_y),
      .mass_i    (req_ff.body_mass),
      .res_o     (ax_res[1])
   );

   sebgb_axis u_axis_z (
      .clock     (clock),
      .gravity_i (gravity_ff[2]),
      .drag_i    (drag_ff),
      .dt_i      (dt_ff),
      .pos_i     (req_ff.pos_z),
      .vel_i     (req_ff.vel_z),
      .mass_i    (req_ff.body_mass),
      .res_o     (ax_res[2])
   );

   sebgb_ground u_ground (
      .clock      (clock),
      .ax_i       (ax_res),
      .radius_i   (rad_dly_ff[AL-1]),
      .fixed_i    (fix_dly_ff[AL-1]),
      .ground_i   (ground_ff),
      .friction_i (friction_ff),
      .rsp_o      (rsp_data)
   );

   assign busy      = busy_ff;
   assign rsp_valid = vld_ff[TL-1];

endmodule

FILE: design/sebgb_div.sv
// ----------------------------------------------------------------------------
// sebgb_div: pipelined restoring divider
// One quotient bit per stage; side data travels alongside each stage.
// ----------------------------------------------------------------------------
module sebgb_div (
   input  logic                    clock,
   input  sebgb_pkg::axis_side_type side_i,
   input  logic [30:0]             rem_i,
   input  logic [31:0]             low_i,
   output sebgb_pkg::axis_side_type side_o,
   output logic [31:0]             quot_o
);

   localparam int N = sebgb_pkg::DIV_STEPS;

   sebgb_pkg::axis_side_type side_ff [N];
   logic [30:0]              rem_ff  [N];
   logic [31:0]              low_ff  [N];
   logic [31:0]              quot_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_step
      sebgb_pkg::axis_side_type side_s;
      logic [30:0]              rem_s;
      logic [31:0]              low_s;
      logic [31:0]              quot_s;
      logic [31:0]              trial;
      logic                     ge;

      if (k == 0) begin : g_first
         assign side_s = side_i;
         assign rem_s  = rem_i;
         assign low_s  = low_i;
         assign quot_s = '0;
      end else begin : g_next
         assign side_s = side_ff[k-1];
         assign rem_s  = rem_ff[k-1];
         assign low_s  = low_ff[k-1];
         assign quot_s = quot_ff[k-1];
      end

      assign trial = {rem_s, low_s[31]};
      assign ge    = trial >= {1'b0, side_s.mass};

      always_ff @(posedge clock) begin
         side_ff[k] <= side_s;
         rem_ff[k]  <= ge ? 31'(trial - {1'b0, side_s.mass}) : trial[30:0];
         low_ff[k]  <= {low_s[30:0], 1'b0};
         quot_ff[k] <= {quot_s[30:0], ge};
      end
   end

   assign side_o = side_ff[N-1];
   assign quot_o = quot_ff[N-1];

endmodule

FILE: design/sebgb_axis.sv
// ----------------------------------------------------------------------------
// sebgb_axis: one axis of the integration step
// Drag product and divide, acceleration, velocity then position update.
// ----------------------------------------------------------------------------
module sebgb_axis (
   input  logic                     clock,
   input  logic signed [31:0]       gravity_i,
   input  logic [30:0]              drag_i,
   input  logic [16:0]              dt_i,
   input  logic signed [31:0]       pos_i,
   input  logic signed [31:0]       vel_i,
   input  logic [30:0]              mass_i,
   output sebgb_pkg::axis_res_type  res_o
);

   // drag product
   logic [62:0]        pd_ff;
   logic signed [31:0] p1_ff, v1_ff;
   logic [30:0]        mass1_ff;

   always_ff @(posedge clock) begin
      pd_ff    <= 63'(drag_i) * 63'(sebgb_pkg::mag32(vel_i));
      p1_ff    <= pos_i;
      v1_ff    <= vel_i;
      mass1_ff <= mass_i;
   end

   // rounding offset and overflow check
   logic [62:0]              n_in;
   logic [62:0]              n2_ff;
   sebgb_pkg::axis_side_type side2_in, side2_ff;

   always_comb begin
      n_in          = pd_ff + 63'(mass1_ff >> 1);
      side2_in.pos  = p1_ff;
      side2_in.vel  = v1_ff;
      side2_in.mass = mass1_ff;
      side2_in.ovf  = n_in[62:32] >= mass1_ff;
      side2_in.skip = (mass1_ff == '0) || (v1_ff == '0);
   end

   always_ff @(posedge clock) begin
      n2_ff    <= n_in;
      side2_ff <= side2_in;
   end

   sebgb_pkg::axis_side_type side_d;
   logic [31:0]              quot_d;

   sebgb_div u_div (
      .clock  (clock),
      .side_i (side2_ff),
      .rem_i  (n2_ff[62:32]),
      .low_i  (n2_ff[31:0]),
      .side_o (side_d),
      .quot_o (quot_d)
   );

   // acceleration
   logic signed [31:0] d_s;
   logic               qbig;
   logic signed [31:0] a_ff, po_a_ff, vo_a_ff;

   always_comb begin
      qbig = side_d.ovf || quot_d[31];
      if (side_d.skip) begin
         d_s = '0;
      end else if (!side_d.vel[31]) begin
         d_s = qbig ? 32'sh80000000 : -$signed({1'b0, quot_d[30:0]});
      end else begin
         d_s = qbig ? 32'sh7FFFFFFF : $signed({1'b0, quot_d[30:0]});
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= sebgb_pkg::sat34(34'(gravity_i) + 34'(d_s));
      po_a_ff <= side_d.pos;
      vo_a_ff <= side_d.vel;
   end

   // velocity product
   logic [49:0]        prod1_ff;
   logic               aneg1_ff;
   logic signed [31:0] po_m1_ff, vo_m1_ff;

   always_ff @(posedge clock) begin
      prod1_ff <= 50'(sebgb_pkg::mag32(a_ff)) * 50'(dt_i);
      aneg1_ff <= a_ff[31];
      po_m1_ff <= po_a_ff;
      vo_m1_ff <= vo_a_ff;
   end

   // velocity update
   logic signed [31:0] vn_r1_ff, po_r1_ff, vo_r1_ff;

   always_ff @(posedge clock) begin
      vn_r1_ff <= sebgb_pkg::sat34(34'(vo_m1_ff)
                  + 34'(sebgb_pkg::round_sat(prod1_ff, aneg1_ff)));
      po_r1_ff <= po_m1_ff;
      vo_r1_ff <= vo_m1_ff;
   end

   // position product
   logic [49:0]        prod2_ff;
   logic               vneg2_ff;
   logic signed [31:0] vn_m2_ff, po_m2_ff, vo_m2_ff;

   always_ff @(posedge clock) begin
      prod2_ff <= 50'(sebgb_pkg::mag32(vn_r1_ff)) * 50'(dt_i);
      vneg2_ff <= vn_r1_ff[31];
      vn_m2_ff <= vn_r1_ff;
      po_m2_ff <= po_r1_ff;
      vo_m2_ff <= vo_r1_ff;
   end

   // position update
   sebgb_pkg::axis_res_type res_ff;

   always_ff @(posedge clock) begin
      res_ff.pos      <= sebgb_pkg::sat34(34'(po_m2_ff)
                         + 34'(sebgb_pkg::round_sat(prod2_ff, vneg2_ff)));
      res_ff.vel      <= vn_m2_ff;
      res_ff.pos_orig <= po_m2_ff;
      res_ff.vel_orig <= vo_m2_ff;
   end

   assign res_o = res_ff;

endmodule

FILE: design/sebgb_ground.sv
// ----------------------------------------------------------------------------
// sebgb_ground: ground contact and output select
// Contact test, height correction, bounce and friction, rest thresholds.
// ----------------------------------------------------------------------------
module sebgb_ground (
   input  logic                               clock,
   input  sebgb_pkg::axis_res_type [2:0]      ax_i,
   input  logic [30:0]                        radius_i,
   input  logic                               fixed_i,
   input  logic signed [31:0]                 ground_i,
   input  logic [16:0]                        friction_i,
   output sebgb_pkg::rsp_type                 rsp_o
);

   logic [16:0]        factor;
   logic signed [33:0] ground34, radius34, py34;

   always_comb begin
      factor   = sebgb_pkg::ONE_Q - ((friction_i > sebgb_pkg::ONE_Q) ?
                                     sebgb_pkg::ONE_Q : friction_i);
      ground34 = 34'(ground_i);
      radius34 = $signed({3'b0, radius_i});
      py34     = 34'(ax_i[1].pos);
   end

   // contact test and products
   sebgb_pkg::axis_res_type [2:0] ax1_ff;
   logic                          hit1_ff, fixed1_ff;
   logic signed [31:0]            pg1_ff;
   logic [49:0]                   px1_ff, py1_ff, pz1_ff;

   always_ff @(posedge clock) begin
      ax1_ff    <= ax_i;
      fixed1_ff <= fixed_i;
      hit1_ff   <= (py34 - radius34) < ground34;
      pg1_ff    <= sebgb_pkg::sat34(ground34 + radius34);
      px1_ff    <= 50'(sebgb_pkg::mag32(ax_i[0].vel)) * 50'(factor);
      py1_ff    <= 50'(sebgb_pkg::mag32(ax_i[1].vel)) * 50'(sebgb_pkg::RESTITUTION_Q);
      pz1_ff    <= 50'(sebgb_pkg::mag32(ax_i[2].vel)) * 50'(factor);
   end

   // bounce, friction, thresholds, select
   logic signed [31:0] vx_h, vy_h, vz_h;
   sebgb_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      vx_h = sebgb_pkg::round_sat(px1_ff, ax1_ff[0].vel[31]);
      vz_h = sebgb_pkg::round_sat(pz1_ff, ax1_ff[2].vel[31]);
      vy_h = ax1_ff[1].vel[31] ? sebgb_pkg::round_sat(py1_ff, 1'b0) : ax1_ff[1].vel;
      if (sebgb_pkg::mag32(vx_h) < sebgb_pkg::VXZ_REST_Q) begin
         vx_h = '0;
      end
      if (sebgb_pkg::mag32(vz_h) < sebgb_pkg::VXZ_REST_Q) begin
         vz_h = '0;
      end
      if (sebgb_pkg::mag32(vy_h) < sebgb_pkg::VY_REST_Q) begin
         vy_h = '0;
      end
      if (fixed1_ff) begin
         rsp_in.new_pos_x  = ax1_ff[0].pos_orig;
         rsp_in.new_pos_y  = ax1_ff[1].pos_orig;
         rsp_in.new_pos_z  = ax1_ff[2].pos_orig;
         rsp_in.new_vel_x  = ax1_ff[0].vel_orig;
         rsp_in.new_vel_y  = ax1_ff[1].vel_orig;
         rsp_in.new_vel_z  = ax1_ff[2].vel_orig;
         rsp_in.hit_ground = 1'b0;
      end else if (hit1_ff) begin
         rsp_in.new_pos_x  = ax1_ff[0].pos;
         rsp_in.new_pos_y  = pg1_ff;
         rsp_in.new_pos_z  = ax1_ff[2].pos;
         rsp_in.new_vel_x  = vx_h;
         rsp_in.new_vel_y  = vy_h;
         rsp_in.new_vel_z  = vz_h;
         rsp_in.hit_ground = 1'b1;
      end else begin
         rsp_in.new_pos_x  = ax1_ff[0].pos;
         rsp_in.new_pos_y  = ax1_ff[1].pos;
         rsp_in.new_pos_z  = ax1_ff[2].pos;
         rsp_in.new_vel_x  = ax1_ff[0].vel;
         rsp_in.new_vel_y  = ax1_ff[1].vel;
         rsp_in.new_vel_z  = ax1_ff[2].vel;
         rsp_in.hit_ground = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_o = rsp_ff;

endmodule
